// ===== rtl/sgcd_pkg.sv =====
// Shared types, codes and gesture helpers for the stick gesture command detector.
package sgcd_pkg;

    localparam logic [1:0] CLS_LO = 2'd1;
    localparam logic [1:0] CLS_HI = 2'd2;
    localparam logic [1:0] CLS_CE = 2'd3;

    localparam logic [2:0] TRIM_NONE     = 3'd0;
    localparam logic [2:0] TRIM_FA_MINUS = 3'd1;
    localparam logic [2:0] TRIM_FA_PLUS  = 3'd2;
    localparam logic [2:0] TRIM_LR_MINUS = 3'd3;
    localparam logic [2:0] TRIM_LR_PLUS  = 3'd4;

    localparam logic [2:0] REG_THROTTLE_CH = 3'd0;
    localparam logic [2:0] REG_ROLL_CH     = 3'd1;
    localparam logic [2:0] REG_PITCH_CH    = 3'd2;
    localparam logic [2:0] REG_YAW_CH      = 3'd3;
    localparam logic [2:0] REG_LOW_THR     = 3'd4;
    localparam logic [2:0] REG_HIGH_THR    = 3'd5;
    localparam logic [2:0] REG_HOLD_MS     = 3'd6;
    localparam logic [2:0] REG_REPEAT_MS   = 3'd7;

    localparam logic [1:0] SET_ONE = 2'd1;
    localparam logic [1:0] SET_TWO = 2'd2;

    typedef struct packed {
        logic [1:0] throttle;
        logic [1:0] roll;
        logic [1:0] pitch;
        logic [1:0] yaw;
    } chan_map_t;

    typedef struct packed {
        logic turn_on;     // same pattern as left-right minus
        logic turn_off;    // same pattern as left-right plus
        logic set1_off;
        logic set2_off;
        logic set1_on;
        logic set2_on;
        logic fa_minus;
        logic fa_plus;
    } gesture_hit_t;

    function automatic logic [9:0] term(input logic [1:0] cls, input logic [1:0] ch);
        return {8'd0, cls} << {ch, 1'b0};
    endfunction

    function automatic logic [9:0] gesture(input chan_map_t m, input logic [1:0] thr,
                                           input logic [1:0] yaw, input logic [1:0] pit,
                                           input logic [1:0] rol);
        return term(thr, m.throttle) + term(yaw, m.yaw) + term(pit, m.pitch)
             + term(rol, m.roll);
    endfunction

endpackage

// ===== rtl/stick_gesture_command_detector_core.sv =====
// Stick gesture command detector top level.
// Path: request captured in the input reg, then the result reg loads once the output side is free.
// Throughput: one request per cycle unless the result register is full and out_ready is low.
// Reset: control, hold state and flags cleared to defaults; config regs to defaults.
module stick_gesture_command_detector_core
    import sgcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stick_0,
    input  logic [7:0]  stick_1,
    input  logic [7:0]  stick_2,
    input  logic [7:0]  stick_3,
    input  logic        armed,
    input  logic        landed,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  active_set,
    output logic        alt_nav_enabled,
    output logic        turn_to_waypoint,
    output logic        reload_request,
    output logic [1:0]  set_beeps,
    output logic        flags_changed,
    output logic [2:0]  trim_command,
    output logic [7:0]  stick_code
);

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_DECODE} phase_t;

    // config
    chan_map_t   chan_reg;
    logic [7:0]  low_thr_reg;
    logic [7:0]  high_thr_reg;
    logic [15:0] hold_ms_reg;
    logic [15:0] repeat_ms_reg;

    // input stage
    logic            in_valid_reg;
    logic [3:0][7:0] sticks_reg;
    logic            armed_reg;
    logic            landed_reg;
    logic [31:0]     now_reg;

    // hold state
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [1:0]  set_reg, set_next;
    logic        alt_reg, alt_next;
    logic        wpt_reg, wpt_next;

    // result stage
    logic        out_valid_reg;
    logic        reload_reg, reload_next;
    logic [1:0]  beeps_reg, beeps_next;
    logic        fchg_reg, fchg_next;
    logic [2:0]  trim_reg, trim_next;
    logic [7:0]  code_reg;

    logic         advance;
    logic [7:0]   code;
    phase_t       phase_trk;
    logic [7:0]   held_trk;
    logic [31:0]  deadline_trk;
    logic [31:0]  hold_end;
    logic [31:0]  repeat_end;
    gesture_hit_t hit;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg.throttle <= 2'd0;
            chan_reg.roll     <= 2'd1;
            chan_reg.pitch    <= 2'd2;
            chan_reg.yaw      <= 2'd3;
            low_thr_reg       <= 8'd30;
            high_thr_reg      <= 8'd170;
            hold_ms_reg       <= 16'd2000;
            repeat_ms_reg     <= 16'd100;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                REG_THROTTLE_CH: chan_reg.throttle <= cfg_data[1:0];
                REG_ROLL_CH:     chan_reg.roll     <= cfg_data[1:0];
                REG_PITCH_CH:    chan_reg.pitch    <= cfg_data[1:0];
                REG_YAW_CH:      chan_reg.yaw      <= cfg_data[1:0];
                REG_LOW_THR:     low_thr_reg       <= cfg_data[7:0];
                REG_HIGH_THR:    high_thr_reg      <= cfg_data[7:0];
                REG_HOLD_MS:     hold_ms_reg       <= cfg_data;
                REG_REPEAT_MS:   repeat_ms_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sticks_reg <= {stick_3, stick_2, stick_1, stick_0};
            armed_reg  <= armed;
            landed_reg <= landed;
            now_reg    <= now_ms;
        end
    end

    sgcd_classify u_classify (
        .sticks         (sticks_reg),
        .low_threshold  (low_thr_reg),
        .high_threshold (high_thr_reg),
        .code           (code)
    );

    assign hold_end   = now_reg + {16'd0, hold_ms_reg};
    assign repeat_end = now_reg + {16'd0, repeat_ms_reg};

    // hold tracking
    always_comb
    begin
        phase_trk    = phase_reg;
        held_trk     = held_reg;
        deadline_trk = deadline_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (held_reg != code)
                begin
                    held_trk     = code;
                    deadline_trk = hold_end;
                    phase_trk    = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (held_reg == code)
                begin
                    if (now_reg > deadline_reg)
                        phase_trk = PH_DECODE;
                end
                else
                    phase_trk = PH_IDLE;
            end
            default: ;
        endcase
    end

    sgcd_gesture u_gesture (
        .held_code (held_trk),
        .chan_map  (chan_reg),
        .hit       (hit)
    );

    always_comb
    begin
        phase_next    = phase_trk;
        held_next     = held_trk;
        deadline_next = deadline_trk;
        set_next      = set_reg;
        alt_next      = alt_reg;
        wpt_next      = wpt_reg;
        reload_next   = 1'b0;
        beeps_next    = 2'd0;
        fchg_next     = 1'b0;
        trim_next     = TRIM_NONE;
        if (!armed_reg)
        begin
            if (phase_trk != PH_IDLE && phase_trk != PH_WAIT)
            begin
                if (hit.turn_on)
                    wpt_next = 1'b1;
                else if (hit.turn_off)
                    wpt_next = 1'b0;
                else if (hit.set1_off)
                begin
                    set_next = SET_ONE;
                    alt_next = 1'b0;
                end
                else if (hit.set2_off)
                begin
                    set_next = SET_TWO;
                    alt_next = 1'b0;
                end
                else if (hit.set1_on)
                begin
                    set_next = SET_ONE;
                    alt_next = 1'b1;
                end
                else if (hit.set2_on)
                begin
                    set_next = SET_TWO;
                    alt_next = 1'b1;
                end
                fchg_next = (alt_next != alt_reg) || (wpt_next != wpt_reg);
                if (set_next != set_reg)
                begin
                    reload_next = 1'b1;
                    beeps_next  = set_next + 2'd1;
                end
                phase_next = PH_IDLE;
            end
        end
        else if (landed_reg)
        begin
            if (phase_trk != PH_IDLE && phase_trk != PH_WAIT)
            begin
                if (hit.fa_minus)
                    trim_next = TRIM_FA_MINUS;
                else if (hit.fa_plus)
                    trim_next = TRIM_FA_PLUS;
                else if (hit.turn_on)
                    trim_next = TRIM_LR_MINUS;
                else if (hit.turn_off)
                    trim_next = TRIM_LR_PLUS;
                if (trim_next != TRIM_NONE)
                begin
                    phase_next    = PH_WAIT;
                    deadline_next = repeat_end;
                end
                else
                    phase_next = PH_IDLE;
            end
        end
        else
        begin
            phase_next    = PH_IDLE;
            held_next     = held_reg;
            deadline_next = deadline_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            held_reg      <= 8'd0;
            deadline_reg  <= 32'd0;
            set_reg       <= SET_ONE;
            alt_reg       <= 1'b0;
            wpt_reg       <= 1'b1;
            reload_reg    <= 1'b0;
            beeps_reg     <= 2'd0;
            fchg_reg      <= 1'b0;
            trim_reg      <= TRIM_NONE;
            code_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg    <= phase_next;
                held_reg     <= held_next;
                deadline_reg <= deadline_next;
                set_reg      <= set_next;
                alt_reg      <= alt_next;
                wpt_reg      <= wpt_next;
                reload_reg   <= reload_next;
                beeps_reg    <= beeps_next;
                fchg_reg     <= fchg_next;
                trim_reg     <= trim_next;
                code_reg     <= code;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign active_set       = set_reg;
    assign alt_nav_enabled  = alt_reg;
    assign turn_to_waypoint = wpt_reg;
    assign reload_request   = reload_reg;
    assign set_beeps        = beeps_reg;
    assign flags_changed    = fchg_reg;
    assign trim_command     = trim_reg;
    assign stick_code       = code_reg;

`ifndef SYNTHESIS
    a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active_set == SET_ONE || active_set == SET_TWO))
        else $error("active set out of range");

    a_reload_beeps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reload_request == (set_beeps != 2'd0)))
        else $error("reload request and set beeps disagree");

    a_trim_landed: assert property (@(posedge clk) disable iff (!rst_n)
        advance && trim_next != TRIM_NONE |-> armed_reg && landed_reg && !reload_next)
        else $error("trim issued outside armed and landed");

    a_phase_known: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (phase_reg == PH_IDLE || phase_reg == PH_WAIT))
        else $error("decode phase left standing");
`endif

endmodule

// ===== rtl/sgcd_classify.sv =====
// Stick classifier: low/high/centre class per stick packed into an 8-bit code.
module sgcd_classify
    import sgcd_pkg::*;
(
    input  logic [3:0][7:0] sticks,
    input  logic [7:0]      low_threshold,
    input  logic [7:0]      high_threshold,
    output logic [7:0]      code
);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            code[2*i+1] = sticks[i] > low_threshold;
            code[2*i]   = sticks[i] < high_threshold;
        end
    end

endmodule

// ===== rtl/sgcd_gesture.sv =====
// Gesture matcher: compares the held code against every command pattern.
module sgcd_gesture
    import sgcd_pkg::*;
(
    input  logic [7:0]   held_code,
    input  chan_map_t    chan_map,
    output gesture_hit_t hit
);

    logic [9:0] code_ext;

    assign code_ext = {2'b00, held_code};

    always_comb
    begin
        hit.turn_on  = code_ext == gesture(chan_map, CLS_LO, CLS_CE, CLS_CE, CLS_HI);
        hit.turn_off = code_ext == gesture(chan_map, CLS_LO, CLS_CE, CLS_CE, CLS_LO);
        hit.set1_off = code_ext == gesture(chan_map, CLS_LO, CLS_HI, CLS_LO, CLS_CE);
        hit.set2_off = code_ext == gesture(chan_map, CLS_LO, CLS_LO, CLS_LO, CLS_CE);
        hit.set1_on  = code_ext == gesture(chan_map, CLS_LO, CLS_HI, CLS_HI, CLS_CE);
        hit.set2_on  = code_ext == gesture(chan_map, CLS_LO, CLS_LO, CLS_HI, CLS_CE);
        hit.fa_minus = code_ext == gesture(chan_map, CLS_LO, CLS_CE, CLS_HI, CLS_CE);
        hit.fa_plus  = code_ext == gesture(chan_map, CLS_LO, CLS_CE, CLS_LO, CLS_CE);
    end

endmodule
